// ===== rtl/lfsa_pkg.sv =====
// Shared types and constants for the lowest-free slot allocator.
// Used by lfsa_front, lfsa_back and lowest_free_slot_allocator_unit.
package lfsa_pkg;

  // Field widths of the request and result items
  localparam int CmdW  = 2;
  localparam int IdW   = 22;
  localparam int IdxW  = 6;
  localparam int SpanW = 7;

  // Depth of the request queue between front and back
  localparam int QDepth = 2;

  // Command codes on the cmd field
  localparam logic [CmdW-1:0] CMD_GET   = 2'd0;
  localparam logic [CmdW-1:0] CMD_PUT   = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd2;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_GET,
    OP_PUT,
    OP_CLR,
    OP_NOP
  } op_t;

  // One queued request
  typedef struct packed {
    op_t            op;
    logic [IdW-1:0] task_id;
  } req_t;

  // One slot entry of the slot store
  typedef struct packed {
    logic           busy;
    logic [IdW-1:0] owner;
  } slot_t;

  // Sequencer states of the back part
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_SWEEP,
    ST_COMMIT
  } st_t;

endpackage

// ===== rtl/lfsa_front.sv =====
// Request front end: accepts requests, classifies the command and queues them.
// Depends on lfsa_pkg.
module lfsa_front
  import lfsa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [CmdW-1:0] cmd,
  input  logic [IdW-1:0]  task_id,
  input  logic            enable,
  output logic            q_valid,
  output req_t            q_req,
  input  logic            q_pop
);

  localparam int QAW = $clog2(QDepth);
  localparam int QCW = $clog2(QDepth + 1);

  req_t           q_mem [QDepth];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  req_t           req_in;

  // Map the command code to an operation
  function automatic op_t classify(input logic [CmdW-1:0] c);
    op_t o;
    case (c)
      CMD_GET:   o = OP_GET;
      CMD_PUT:   o = OP_PUT;
      CMD_CLEAR: o = OP_CLR;
      default:   o = OP_NOP;
    endcase
    return o;
  endfunction

  // Hold requests off while the store is cleared after reset or the queue is full
  assign in_stall = !enable || (count == QCW'(QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_req    = q_mem[rd_ptr];

  always_comb begin
    req_in.op      = classify(cmd);
    req_in.task_id = task_id;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= req_in;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + QCW'(push) - QCW'(q_pop);
    end
  end

endmodule

// ===== rtl/lfsa_back.sv =====
// Request back end: slot store, scan sequencer and result register.
// Depends on lfsa_pkg.
module lfsa_back
  import lfsa_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  req_t             q_req,
  output logic             q_pop,
  output logic             init_done,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IdxW-1:0]  slot_index,
  output logic             newly_given,
  output logic             was_present,
  output logic             no_room,
  output logic [SpanW-1:0] span_in_use
);

  localparam int AW = $clog2(SLOTS);
  localparam int SW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] LAST   = AW'(SLOTS - 1);
  localparam logic [SW-1:0] SLOTSW = SW'(SLOTS);

  st_t            state;
  st_t            state_next;
  logic [AW-1:0]  cnt;
  op_t            cur_op;
  logic [IdW-1:0] cur_id;
  logic [SW-1:0]  span;

  // Slot store and its registered read
  slot_t          mem [SLOTS];
  slot_t          rd_data;
  logic           rd_vld;
  logic [AW-1:0]  rd_idx;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  slot_t          mem_wdata;

  // Scan results
  logic           hit_f;
  logic [AW-1:0]  hit_idx;
  logic           free_f;
  logic [AW-1:0]  free_idx;
  logic           hi_f;
  logic [AW-1:0]  hi_idx;
  logic           match;

  // Outcome of the current request
  logic           out_free;
  logic           commit;
  logic [AW-1:0]  res_idx;
  logic           res_fresh;
  logic           res_present;
  logic           res_full;
  logic [SW-1:0]  res_span;
  logic           res_we;
  logic [AW-1:0]  res_waddr;
  logic           res_busy;
  logic [AW+IdxW-1:0]  idx_wide;
  logic [SW+SpanW-1:0] span_wide;

  assign out_free  = !out_valid || !out_stall;
  assign init_done = (state != ST_INIT);
  assign match     = rd_data.busy && (rd_data.owner == cur_id);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (cnt == LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          case (q_req.op)
            OP_GET, OP_PUT: state_next = ST_SCAN;
            OP_CLR:         state_next = ST_SWEEP;
            default:        state_next = ST_COMMIT;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt == LAST) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        state_next = ST_COMMIT;
      end
      ST_SWEEP: begin
        if (cnt == LAST) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Decide the outcome from the scan results
  always_comb begin
    res_idx     = '0;
    res_fresh   = 1'b0;
    res_present = 1'b0;
    res_full    = 1'b0;
    res_span    = span;
    res_we      = 1'b0;
    res_waddr   = '0;
    res_busy    = 1'b0;
    case (cur_op)
      OP_GET: begin
        if (hit_f) begin
          res_present = 1'b1;
          res_idx     = hit_idx;
        end else if (free_f) begin
          res_fresh = 1'b1;
          res_idx   = free_idx;
          res_we    = 1'b1;
          res_waddr = free_idx;
          res_busy  = 1'b1;
        end else if (span < SLOTSW) begin
          res_fresh = 1'b1;
          res_idx   = AW'(span);
          res_we    = 1'b1;
          res_waddr = AW'(span);
          res_busy  = 1'b1;
          res_span  = span + SW'(1);
        end else begin
          res_full = 1'b1;
        end
      end
      OP_PUT: begin
        if (hit_f) begin
          res_present = 1'b1;
          res_we      = 1'b1;
          res_waddr   = hit_idx;
          res_busy    = 1'b0;
          res_span    = hi_f ? (SW'(hi_idx) + SW'(1)) : '0;
        end
      end
      OP_CLR: begin
        res_span = '0;
      end
      default: begin
        res_span = span;
      end
    endcase
  end

  // Sequencer outputs: queue pop, store write, commit
  always_comb begin
    q_pop     = 1'b0;
    commit    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '{busy: 1'b0, owner: cur_id};
    case (state)
      ST_IDLE: begin
        q_pop = q_valid;
      end
      ST_INIT, ST_SWEEP: begin
        mem_we = 1'b1;
      end
      ST_COMMIT: begin
        commit    = out_free;
        mem_we    = out_free && res_we;
        mem_waddr = res_waddr;
        mem_wdata = '{busy: res_busy, owner: cur_id};
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // State, counter and span
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
      span  <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        cnt <= '0;
      end else if (state == ST_INIT || state == ST_SCAN || state == ST_SWEEP) begin
        cnt <= cnt + AW'(1);
      end
      if (commit) begin
        span <= res_span;
      end
    end
  end

  // Capture the request being worked on
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_op <= q_req.op;
      cur_id <= q_req.task_id;
    end
  end

  // Slot store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cnt];
    rd_idx  <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
    end
  end

  // Fold each scanned entry into hit, lowest free and highest other busy
  always_ff @(posedge clk) begin
    if (rst || q_pop) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
      hi_f   <= 1'b0;
    end else if (rd_vld) begin
      if (match) begin
        hit_f <= 1'b1;
      end
      if (!rd_data.busy && !free_f && (SW'(rd_idx) < span)) begin
        free_f <= 1'b1;
      end
      if (rd_data.busy && !match) begin
        hi_f <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      if (match) begin
        hit_idx <= rd_idx;
      end
      if (!rd_data.busy && !free_f && (SW'(rd_idx) < span)) begin
        free_idx <= rd_idx;
      end
      if (rd_data.busy && !match) begin
        hi_idx <= rd_idx;
      end
    end
  end

  // Result register
  assign idx_wide  = {{IdxW{1'b0}}, res_idx};
  assign span_wide = {{SpanW{1'b0}}, res_span};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      slot_index  <= idx_wide[IdxW-1:0];
      newly_given <= res_fresh;
      was_present <= res_present;
      no_room     <= res_full;
      span_in_use <= span_wide[SpanW-1:0];
    end
  end

endmodule

// ===== rtl/lowest_free_slot_allocator_unit.sv =====
// Top level of the lowest-free slot allocator: front end, queue and back end.
// Depends on lfsa_pkg, lfsa_front and lfsa_back.

// Hands out SLOTS slots to task ids. A get returns the slot an id already
// holds, else the lowest free slot below the span in use, else appends at
// the span, else reports no_room. A release frees the id's slot and pulls
// the span back to the highest occupied slot plus one; a clear empties all.
// One result comes out per request. The slot store is a memory with one
// write and one read port that is scanned one entry per cycle; a get or
// release scans every entry, a clear sweeps the whole store and an unused
// command goes straight to its result. A two-entry request queue takes new
// requests while the back end works. After reset the store is cleared in
// one pass over all SLOTS entries, during which in_stall stays high.
module lowest_free_slot_allocator_unit
  import lfsa_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CmdW-1:0]  cmd,
  input  logic [IdW-1:0]   task_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IdxW-1:0]  slot_index,
  output logic             newly_given,
  output logic             was_present,
  output logic             no_room,
  output logic [SpanW-1:0] span_in_use
);

  logic q_valid;
  req_t q_req;
  logic q_pop;
  logic init_done;

  // Accept and classify requests
  lfsa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .task_id  (task_id),
    .enable   (init_done),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  // Carry out requests against the slot store
  lfsa_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop),
    .init_done   (init_done),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_index  (slot_index),
    .newly_given (newly_given),
    .was_present (was_present),
    .no_room     (no_room),
    .span_in_use (span_in_use)
  );

  // A fresh slot never goes to an id that held one, nor with no_room
  a_fresh_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && newly_given |-> !was_present && !no_room)
    else $error("fresh slot flagged together with present or no_room");

  // No room and present are exclusive
  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_room |-> !was_present)
    else $error("no_room flagged for an id that held a slot");

  // Requests are held off right after reset while the store is cleared
  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("request taken during the clearing pass");

  // Pop the queue only while it holds a request
  a_queue_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
